[hdl/rrbc_pkg.sv]
// Shared types, constants and helpers for the ROM/RAM bank controller.
// No dependencies; imported by rrbc_regs, the top level and the testbench.
package rrbc_pkg;

    // default build-time sizes
    localparam int RAM_BANKS_DEF      = 4;
    localparam int RAM_BANK_BYTES_DEF = 8192;  // power of two, 2048 to 8192
    localparam int ROM_BANK_BITS_DEF  = 7;

    // result codes
    localparam logic [2:0] OUT_ROM_ADDR   = 3'd0;
    localparam logic [2:0] OUT_RAM_DATA   = 3'd1;
    localparam logic [2:0] OUT_WRITE_DONE = 3'd2;
    localparam logic [2:0] OUT_RAM_OFF    = 3'd3;
    localparam logic [2:0] OUT_UNMAPPED   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd0;
    localparam logic [1:0] CFG_RAM_BANK_COUNT = 2'd1;

    // control register regions below 0x8000, selected by address bits 14:13
    localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REG_ROM_BANK   = 2'd1;
    localparam logic [1:0] REG_UPPER_BITS = 2'd2;
    localparam logic [1:0] REG_MODE       = 2'd3;

    localparam logic [2:0] RAM_WINDOW     = 3'b101;  // 0xA000-0xBFFF
    localparam logic [3:0] RAM_EN_KEY     = 4'hA;

    localparam logic [7:0] ROM_COUNT_RST  = 8'd128;
    localparam logic [2:0] RAM_COUNT_RST  = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [20:0] rom_address;
        logic [7:0]  read_data;
    } rsp_item_t;

    // decoded access, from the register block to the pipeline
    typedef struct packed {
        logic [2:0]  outcome;
        logic [20:0] rom_address;
        logic        ram_rd;
        logic        ram_wr;
    } access_t;

    // RAM bank number modulo the effective bank count (1 to 4)
    function automatic logic [1:0] ram_bank_wrap(input logic [1:0] bank,
                                                 input logic [2:0] cnt);
        logic [1:0] res;
        case (cnt)
            3'd1:    res = 2'd0;
            3'd2:    res = {1'b0, bank[0]};
            3'd3:    res = (bank == 2'd3) ? 2'd0 : bank;
            default: res = bank;
        endcase
        return res;
    endfunction

endpackage

[hdl/rrbc_ram.sv]
// Generic single-port synchronous RAM, registered read, one access per cycle.
// No dependencies.
module rrbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rrbc_regs.sv]
// Configuration and bank registers with the bus access decode.
// Depends on rrbc_pkg.
module rrbc_regs #(
    parameter int RAM_BANKS      = 4,
    parameter int RAM_BANK_BYTES = 8192,
    parameter int ROM_BANK_BITS  = 7,
    localparam int STORE_AW      = $clog2(RAM_BANKS * RAM_BANK_BYTES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   accept,
    input  rrbc_pkg::req_item_t    req,
    output rrbc_pkg::access_t      access,
    output logic [STORE_AW-1:0]    ram_index
);
    import rrbc_pkg::*;

    localparam int OFF_BITS = $clog2(RAM_BANK_BYTES);
    localparam logic [6:0] BANK_MASK = 7'((1 << ROM_BANK_BITS) - 1);
    localparam logic [2:0] BANKS_CAP = 3'(RAM_BANKS);

    logic [7:0] rom_count_reg;
    logic [2:0] ram_count_reg;
    logic       ram_en_reg,     ram_en_next;
    logic       mode_reg,       mode_next;
    logic [6:0] upper_reg,      upper_next;
    logic [6:0] lower_reg,      lower_next;
    logic [1:0] ram_bank_reg,   ram_bank_next;

    logic       big;
    logic [7:0] count_m1;
    logic [4:0] low_bits;
    logic [6:0] rom_bank;
    logic [2:0] ram_cnt;
    logic [1:0] eff_bank;
    logic [OFF_BITS-1:0] offset;
    logic       is_write;

    assign big      = rom_count_reg > 8'd16;
    assign count_m1 = rom_count_reg - 8'd1;
    assign is_write = req.operation;

    // bank register update on control writes
    always_comb
    begin
        ram_en_next   = ram_en_reg;
        mode_next     = mode_reg;
        upper_next    = upper_reg;
        lower_next    = lower_reg;
        ram_bank_next = ram_bank_reg;
        low_bits      = req.write_data[4:0];
        if (low_bits == 5'd0)
            low_bits = 5'd1;
        low_bits = low_bits & count_m1[4:0];
        if (accept && is_write && !req.address[15])
        begin
            case (req.address[14:13])
                REG_RAM_ENABLE:
                    ram_en_next = (req.write_data[3:0] == RAM_EN_KEY);
                REG_ROM_BANK:
                    upper_next = {upper_reg[6:5], low_bits} & BANK_MASK;
                REG_UPPER_BITS:
                begin
                    if (big)
                    begin
                        upper_next = {req.write_data[1:0], upper_reg[4:0]} & BANK_MASK;
                        if (mode_reg)
                            lower_next = {req.write_data[1:0], 5'd0} & BANK_MASK;
                    end
                    else if (mode_reg && ram_count_reg == 3'd4)
                        ram_bank_next = req.write_data[1:0];
                end
                default:
                begin
                    mode_next = req.write_data[0];
                    if (!req.write_data[0])
                    begin
                        lower_next    = 7'd0;
                        ram_bank_next = 2'd0;
                    end
                    else if (big)
                        lower_next = {upper_reg[6:5], 5'd0} & BANK_MASK;
                    else
                        ram_bank_next = upper_reg[6:5];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_count_reg <= ROM_COUNT_RST;
            ram_count_reg <= RAM_COUNT_RST;
            ram_en_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            upper_reg     <= 7'd1;
            lower_reg     <= 7'd0;
            ram_bank_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_wr && cfg_index == CFG_ROM_BANK_COUNT)
                rom_count_reg <= cfg_data;
            if (cfg_wr && cfg_index == CFG_RAM_BANK_COUNT)
                ram_count_reg <= cfg_data[2:0];
            ram_en_reg   <= ram_en_next;
            mode_reg     <= mode_next;
            upper_reg    <= upper_next;
            lower_reg    <= lower_next;
            ram_bank_reg <= ram_bank_next;
        end
    end

    // access decode
    assign rom_bank = (req.address[14] ? upper_reg : lower_reg) & count_m1[6:0] & BANK_MASK;
    assign ram_cnt  = (ram_count_reg > BANKS_CAP) ? BANKS_CAP : ram_count_reg;
    assign eff_bank = ram_bank_wrap(ram_bank_reg, ram_cnt);
    assign offset   = req.address[OFF_BITS-1:0];
    assign ram_index = STORE_AW'(32'(eff_bank) * RAM_BANK_BYTES + 32'(offset));

    always_comb
    begin
        access = '0;
        access.outcome = OUT_UNMAPPED;
        if (!req.address[15])
        begin
            if (is_write)
                access.outcome = OUT_WRITE_DONE;
            else
            begin
                access.outcome     = OUT_ROM_ADDR;
                access.rom_address = {rom_bank, req.address[13:0]};
            end
        end
        else if (req.address[15:13] == RAM_WINDOW && ram_count_reg != 3'd0)
        begin
            if (!ram_en_reg)
                access.outcome = OUT_RAM_OFF;
            else if (is_write)
            begin
                access.outcome = OUT_WRITE_DONE;
                access.ram_wr  = 1'b1;
            end
            else
            begin
                access.outcome = OUT_RAM_DATA;
                access.ram_rd  = 1'b1;
            end
        end
    end

endmodule

[hdl/rom_ram_bank_controller_core.sv]
// Top level of the ROM/RAM bank controller: access pipeline around the RAM.
// Depends on rrbc_pkg, rrbc_regs and rrbc_ram.
//
// Usage:
//   req channel: one bus access per transaction (operation, address, write
//   data), taken when req_valid is high and req_stall low.
//   rsp channel: exactly one result per access, in order, taken when
//   rsp_valid is high and rsp_stall low.
//   cfg channel: register index and data, cfg_ready is always high; index 0
//   is the ROM bank count, index 1 the RAM bank count. Write only when idle.
// Path: an accepted access is registered into stage 1 alongside the
// registered read of the banked RAM, then moves to the output register.
// Throughput: one access per cycle when rsp_stall is low, set by the single
// RAM port, which sees at most one read or write per accepted access.
// Stalls: a held result sits in the output register while one more access
// may be accepted into the RAM read stage; only then is req_stall raised.
// Reset: bank registers and counts take their reset values, both stages
// empty. RAM contents are undefined until written. RAM_BANK_BYTES must be
// a power of two.
module rom_ram_bank_controller_core #(
    parameter int RAM_BANKS      = rrbc_pkg::RAM_BANKS_DEF,
    parameter int RAM_BANK_BYTES = rrbc_pkg::RAM_BANK_BYTES_DEF,
    parameter int ROM_BANK_BITS  = rrbc_pkg::ROM_BANK_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rrbc_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rrbc_pkg::rsp_item_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import rrbc_pkg::*;

    localparam int STORE_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    access_t             access;
    logic [STORE_AW-1:0] ram_index;
    logic [7:0]          ram_rdata;
    logic                accept;
    logic                s1_move;

    logic        s1_valid_reg;
    logic [2:0]  s1_outcome_reg;
    logic [20:0] s1_rom_reg;
    logic        s1_rd_reg;
    logic        rsp_valid_reg;
    rsp_item_t   rsp_reg;

    assign cfg_ready = 1'b1;
    assign s1_move   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = s1_valid_reg && !s1_move;
    assign accept    = req_valid && !req_stall;

    rrbc_regs #(
        .RAM_BANKS      (RAM_BANKS),
        .RAM_BANK_BYTES (RAM_BANK_BYTES),
        .ROM_BANK_BITS  (ROM_BANK_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req       (req),
        .access    (access),
        .ram_index (ram_index)
    );

    // read data stays put while stage 1 waits, since no new access is issued
    rrbc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (accept && (access.ram_rd || access.ram_wr)),
        .we    (access.ram_wr),
        .addr  (ram_index),
        .wdata (req.write_data),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_outcome_reg <= access.outcome;
            s1_rom_reg     <= access.rom_address;
            s1_rd_reg      <= access.ram_rd;
        end
        if (s1_move && s1_valid_reg)
        begin
            rsp_reg.outcome     <= s1_outcome_reg;
            rsp_reg.rom_address <= s1_rom_reg;
            rsp_reg.read_data   <= s1_rd_reg ? ram_rdata : 8'd0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[tb/sv/rom_ram_bank_controller_core_test.sv]
// Self-checking testbench for rom_ram_bank_controller_core: directed accesses, then random
// bus traffic over several bank-count settings, checked against typed results or a local model.
// Depends on rrbc_pkg and the RTL under hdl/.
module rom_ram_bank_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rrbc_pkg::*;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int RANDOM_PER_PHASE = 155;
    localparam int PHASES           = 10;

    // directed row: access, flag for a typed-in result, the result itself
    typedef struct packed {
        req_item_t item;
        logic      typed;
        rsp_item_t result;
    } access_row_t;

    localparam access_row_t DIRECTED_ROWS [25] = '{
        {OP_READ,  16'h0000, 8'h00, 1'b1, OUT_ROM_ADDR,   21'h000000, 8'h00},
        {OP_READ,  16'h3FFF, 8'hA5, 1'b1, OUT_ROM_ADDR,   21'h003FFF, 8'h00},
        {OP_READ,  16'h4000, 8'h00, 1'b1, OUT_ROM_ADDR,   21'h004000, 8'h00},
        {OP_READ,  16'h7FFF, 8'hFF, 1'b1, OUT_ROM_ADDR,   21'h007FFF, 8'h00},
        {OP_READ,  16'hA000, 8'h00, 1'b1, OUT_RAM_OFF,    21'h000000, 8'h00},
        {OP_WRITE, 16'hBFFF, 8'hFF, 1'b1, OUT_RAM_OFF,    21'h000000, 8'h00},
        {OP_READ,  16'h8000, 8'h00, 1'b1, OUT_UNMAPPED,   21'h000000, 8'h00},
        {OP_WRITE, 16'h9FFF, 8'hFF, 1'b1, OUT_UNMAPPED,   21'h000000, 8'h00},
        {OP_READ,  16'hC000, 8'h00, 1'b1, OUT_UNMAPPED,   21'h000000, 8'h00},
        {OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, OUT_UNMAPPED,   21'h000000, 8'h00},
        {OP_WRITE, 16'h0000, 8'hFA, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00},
        {OP_WRITE, 16'hA000, 8'hFF, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00},
        {OP_READ,  16'hA000, 8'h00, 1'b1, OUT_RAM_DATA,   21'h000000, 8'hFF},
        {OP_WRITE, 16'hBFFF, 8'h00, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00},
        {OP_READ,  16'hBFFF, 8'hFF, 1'b1, OUT_RAM_DATA,   21'h000000, 8'h00},
        {OP_WRITE, 16'h3FFF, 8'h1F, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00},
        {OP_WRITE, 16'h4000, 8'h03, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00},
        {OP_READ,  16'h7FFF, 8'h00, 1'b1, OUT_ROM_ADDR,   21'h1FFFFF, 8'h00},
        {OP_WRITE, 16'h2000, 8'hE0, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00},
        {OP_READ,  16'h4000, 8'h00, 1'b1, OUT_ROM_ADDR,   21'h184000, 8'h00},
        {OP_WRITE, 16'h6000, 8'h01, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00},
        {OP_READ,  16'h0000, 8'h00, 1'b1, OUT_ROM_ADDR,   21'h180000, 8'h00},
        {OP_WRITE, 16'h7FFF, 8'hFE, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00},
        {OP_READ,  16'h3FFF, 8'h00, 1'b1, OUT_ROM_ADDR,   21'h003FFF, 8'h00},
        {OP_WRITE, 16'h1FFF, 8'h0B, 1'b0, OUT_WRITE_DONE, 21'h000000, 8'h00}
    };

    // bank-count settings walked phase by phase: {rom banks, ram banks}
    localparam logic [10:0] BANK_SETTINGS [PHASES] = '{
        {8'd128, 3'd4}, {8'd2, 3'd0}, {8'd16, 3'd4}, {8'd32, 3'd1}, {8'd8, 3'd2},
        {8'd100, 3'd3}, {8'd4, 3'd4}, {8'd64, 3'd1}, {8'd128, 3'd0}, {8'd3, 3'd4}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ROM_BANK_COUNT;
    logic [7:0]  cfg_data  = '0;

    // model state
    logic [7:0]  m_rom_count = ROM_COUNT_RST;
    logic [2:0]  m_ram_count = RAM_COUNT_RST;
    logic        m_ram_on    = 1'b0;
    logic        m_mode      = 1'b0;
    logic [6:0]  m_upper     = 7'd1;
    logic [6:0]  m_lower     = 7'd0;
    logic [1:0]  m_ram_bank  = 2'd0;
    logic [7:0]  cart_ram [32768];
    bit          ram_written [32768];

    rsp_item_t   pending_rsp [$];
    int          mismatch_count = 0;
    int          req_calm = 0;
    int          rsp_calm = 0;

    rom_ram_bank_controller_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycles to hold off before the next transaction; calm stretches give back-to-back runs
    function automatic int draw_wait(inout int calm_left);
        int n;
        n = 0;
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 24) == 0)
            calm_left = $urandom_range(8, 40);
        else
            n = $urandom_range(0, 15);
        return n;
    endfunction

    // store index of a RAM window address under the current bank state
    function automatic logic [14:0] ram_slot(input logic [15:0] address);
        int unsigned cnt;
        int unsigned bank;
        cnt  = (m_ram_count > 3'd4) ? 4 : m_ram_count;
        bank = m_ram_bank % cnt;
        return {2'(bank), address[12:0]};
    endfunction

    // result of one bus access; advances the bank registers and RAM copy
    function automatic rsp_item_t decode_access(input req_item_t it);
        rsp_item_t  r;
        logic [7:0] cnt_m1;
        logic [4:0] n;
        logic [6:0] bank;
        logic [14:0] slot;
        logic       big;
        r         = '0;
        r.outcome = OUT_UNMAPPED;
        cnt_m1    = m_rom_count - 8'd1;
        big       = m_rom_count > 8'd16;
        if (!it.address[15])
        begin
            if (it.operation == OP_WRITE)
            begin
                r.outcome = OUT_WRITE_DONE;
                case (it.address[14:13])
                    REG_RAM_ENABLE:
                        m_ram_on = (it.write_data[3:0] == RAM_EN_KEY);
                    REG_ROM_BANK:
                    begin
                        n = it.write_data[4:0];
                        if (n == 5'd0)
                            n = 5'd1;
                        n = n & cnt_m1[4:0];
                        m_upper = {m_upper[6:5], n};
                    end
                    REG_UPPER_BITS:
                    begin
                        if (big)
                        begin
                            m_upper[6:5] = it.write_data[1:0];
                            if (m_mode)
                                m_lower = {it.write_data[1:0], 5'd0};
                        end
                        else if (m_mode && m_ram_count == 3'd4)
                            m_ram_bank = it.write_data[1:0];
                    end
                    default:
                    begin
                        m_mode = it.write_data[0];
                        if (!m_mode)
                        begin
                            m_lower    = 7'd0;
                            m_ram_bank = 2'd0;
                        end
                        else if (big)
                            m_lower = {m_upper[6:5], 5'd0};
                        else
                            m_ram_bank = m_upper[6:5];
                    end
                endcase
            end
            else
            begin
                bank          = (it.address[14] ? m_upper : m_lower) & cnt_m1[6:0];
                r.rom_address = {bank, it.address[13:0]};
                r.outcome     = OUT_ROM_ADDR;
            end
        end
        else if (it.address[15:13] == RAM_WINDOW && m_ram_count != 3'd0)
        begin
            if (!m_ram_on)
                r.outcome = OUT_RAM_OFF;
            else
            begin
                slot = ram_slot(it.address);
                if (it.operation == OP_WRITE)
                begin
                    cart_ram[slot]    = it.write_data;
                    ram_written[slot] = 1'b1;
                    r.outcome         = OUT_WRITE_DONE;
                end
                else
                begin
                    r.read_data = cart_ram[slot];
                    r.outcome   = OUT_RAM_DATA;
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input rsp_item_t want, input rsp_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected outcome %0d rom %h data %h, got outcome %0d rom %h data %h",
                     $realtime, what, want.outcome, want.rom_address, want.read_data,
                     got.outcome, got.rom_address, got.read_data);
    endtask

    // caller lowers cfg_valid once the last write has gone
    task automatic write_setting(input logic [1:0] index, input logic [7:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index == CFG_ROM_BANK_COUNT)
            m_rom_count = value;
        else
            m_ram_count = value[2:0];
    endtask

    task automatic send_access(input req_item_t item, input logic typed, input rsp_item_t fixed);
        int        gap;
        rsp_item_t predicted;
        gap = draw_wait(req_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = decode_access(item);
        pending_rsp.push_back(typed ? fixed : predicted);
    endtask

    // result side: random stall before each transaction, then compare with the oldest prediction
    initial
    begin : rsp_side
        int        hold;
        rsp_item_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = draw_wait(rsp_calm);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            if (pending_rsp.size() == 0)
                flag_mismatch("unexpected result", '0, rsp);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.outcome !== want.outcome || rsp.rom_address !== want.rom_address ||
                    rsp.read_data !== want.read_data)
                    flag_mismatch("result mismatch", want, rsp);
            end
        end
    end

    initial
    begin : req_side
        req_item_t item;
        int        kind;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_setting(CFG_ROM_BANK_COUNT, BANK_SETTINGS[phase][10:3]);
            write_setting(CFG_RAM_BANK_COUNT, {5'd0, BANK_SETTINGS[phase][2:0]});
            cfg_valid <= 1'b0;
            if (phase == 0)
                foreach (DIRECTED_ROWS[r])
                    send_access(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed,
                                DIRECTED_ROWS[r].result);
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                kind            = $urandom_range(0, 99);
                item.operation  = 1'($urandom_range(0, 1));
                item.write_data = 8'($urandom);
                if (kind < 25)
                begin
                    item.operation = OP_READ;
                    item.address   = {1'b0, 15'($urandom)};
                end
                else if (kind < 45)
                begin
                    item.operation = OP_WRITE;
                    item.address   = {1'b0, 15'($urandom)};
                    if (item.address[14:13] == REG_RAM_ENABLE && $urandom_range(0, 9) < 6)
                        item.write_data[3:0] = RAM_EN_KEY;
                end
                else if (kind < 85)
                begin
                    // mostly a small pool of offsets so reads find earlier writes
                    item.address = {RAM_WINDOW, ($urandom_range(0, 3) == 0) ?
                                    13'($urandom) : 13'($urandom_range(0, 31))};
                end
                else
                    item.address = 16'($urandom);
                // never read a RAM byte that has not been written
                if (item.operation == OP_READ && item.address[15:13] == RAM_WINDOW &&
                    m_ram_count != 3'd0 && m_ram_on && !ram_written[ram_slot(item.address)])
                    item.operation = OP_WRITE;
                send_access(item, 1'b0, '0);
            end
            req_valid <= 1'b0;
            // drain before touching the configuration again
            while (pending_rsp.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
hdl/rrbc_pkg.sv
hdl/rrbc_ram.sv
hdl/rrbc_regs.sv
hdl/rom_ram_bank_controller_core.sv
tb/sv/rom_ram_bank_controller_core_test.sv
